FILE: rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the covering sieve RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CSF_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define CSF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/csf_pkg.sv
// csf_pkg: widths, constants and stage types of the covering sieve filter.
// No dependencies.
package csf_pkg;

  // Fixed field widths
  localparam int P_W    = 63;
  localparam int ROW_W  = 32;
  localparam int TAG_W  = 16;
  localparam int RES_W  = 62;
  localparam int CFG_W  = 24;
  localparam int CIDX_W = 3;
  localparam int LOG_W  = 6;

  // Register file layout: slot 0 is the new modulus, slots 1..6 the priors
  localparam int PRIOR_REGS = 6;
  localparam int SLOT_COUNT = PRIOR_REGS + 1;
  localparam logic [CIDX_W-1:0] REG_TRIAGE = CIDX_W'(PRIOR_REGS + 1);

  // Parameter defaults
  localparam int MAX_POSITIONS_DEF = 62;
  localparam int PRIOR_SLOTS_DEF   = 6;
  localparam int MODULUS_WIDTH_DEF = 24;

  // Control that travels with a word through the bit-step stages
  typedef struct packed {
    logic             valid;
    logic             lead;   // leading one of p seen
    logic [LOG_W-1:0] msb;    // bits consumed after the leading one = floor(log2 p)
    logic [1:0]       ones;   // ones after the leading one, saturating at 2
    logic             last;   // most recent bit
  } stage_ctl_t;

  // Pass-through tag fields
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [TAG_W-1:0] file;
    logic             batch_last;
  } row_tag_t;

endpackage

FILE: rtl/csf_mod_step.sv
// csf_mod_step: one register stage of the bit-serial p mod s reduction,
// all slots in parallel, plus leading-one tracking. Uses csf_pkg.
module csf_mod_step #(
  parameter int MODULUS_WIDTH = csf_pkg::MODULUS_WIDTH_DEF,
  parameter int BIT_POS       = 0
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  adv,
  input  csf_pkg::stage_ctl_t                                   ctl_i,
  input  logic [csf_pkg::P_W-1:0]                               p_i,
  input  csf_pkg::row_tag_t                                     tag_i,
  input  logic [csf_pkg::SLOT_COUNT-1:0][MODULUS_WIDTH-1:0]     rem_i,
  input  logic [csf_pkg::SLOT_COUNT-1:0][MODULUS_WIDTH-1:0]     mod_i,
  output csf_pkg::stage_ctl_t                                   ctl_o,
  output logic [csf_pkg::P_W-1:0]                               p_o,
  output csf_pkg::row_tag_t                                     tag_o,
  output logic [csf_pkg::SLOT_COUNT-1:0][MODULUS_WIDTH-1:0]     rem_o
);
  import csf_pkg::*;
  `include "assert_macros.svh"

  localparam int MW = MODULUS_WIDTH;

  stage_ctl_t                          ctl_r, ctl_nxt;
  logic [P_W-1:0]                      p_r;
  row_tag_t                            tag_r;
  logic [SLOT_COUNT-1:0][MW-1:0]       rem_r, rem_nxt;
  logic                                bit_in;

  assign bit_in = p_i[BIT_POS];

  // Shift one bit of p into each remainder, subtract s once if needed
  always_comb begin
    logic [MW:0] t;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      t = {rem_i[i], bit_in};
      if (t >= {1'b0, mod_i[i]}) begin
        t = t - {1'b0, mod_i[i]};
      end
      rem_nxt[i] = t[MW-1:0];
    end
  end

  // Leading-one, log2 and tail-shape tracking
  always_comb begin
    ctl_nxt = ctl_i;
    if (!ctl_i.lead) begin
      ctl_nxt.lead = bit_in;
      ctl_nxt.msb  = '0;
      ctl_nxt.ones = '0;
      ctl_nxt.last = 1'b0;
    end else begin
      ctl_nxt.msb  = ctl_i.msb + LOG_W'(1);
      ctl_nxt.last = bit_in;
      if (bit_in && ctl_i.ones != 2'd2) begin
        ctl_nxt.ones = ctl_i.ones + 2'd1;
      end
    end
  end

  // Stage register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
      p_r   <= p_i;
      tag_r <= tag_i;
      rem_r <= rem_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign p_o   = p_r;
  assign tag_o = tag_r;
  assign rem_o = rem_r;

  // A valid word carries partial remainders below a nonzero modulus; checked for slots 0 and 1
  `CSF_ASSERT_IMPL(a_rem_new_below, clk, rst_n, ctl_r.valid && mod_i[0] != '0, rem_r[0] < mod_i[0])
  `CSF_ASSERT_IMPL(a_rem_p0_below, clk, rst_n, ctl_r.valid && mod_i[1] != '0, rem_r[1] < mod_i[1])

endmodule

FILE: rtl/covering_sieve_filter.sv
// covering_sieve_filter: top level of the covering-system prime filter.
// Uses csf_pkg, csf_mod_step and assert_macros.svh.
//
//  channel | ports                               | direction
//  in      | in_valid, in_stall, in_* fields     | word in,  in_stall driven here
//  out     | out_valid, out_stall, out_* fields  | word out, out_stall driven by sink
//  cfg     | cfg_we, cfg_index, cfg_data         | register write, no handshake
//
// One word per cycle while in_stall is low; one bit-step stage per bit
// of p for the remainders, then a residue-compare stage and the output stage.
// Each modulus write rebuilds that slot's 2^m mod s table with in_stall high; reset
// starts the same rebuild of slot 0.
// out_stall freezes the whole pipe while out_valid is high; nothing is dropped or repeated.
module covering_sieve_filter #(
  parameter int MAX_POSITIONS = csf_pkg::MAX_POSITIONS_DEF,
  parameter int PRIOR_SLOTS   = csf_pkg::PRIOR_SLOTS_DEF,
  parameter int MODULUS_WIDTH = csf_pkg::MODULUS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [csf_pkg::P_W-1:0]       in_prime_value,
  input  logic [csf_pkg::ROW_W-1:0]     in_row_position,
  input  logic [csf_pkg::TAG_W-1:0]     in_file_tag,
  input  logic                          in_batch_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_covered,
  output logic [csf_pkg::RES_W-1:0]     out_residual_mask,
  output logic [csf_pkg::ROW_W-1:0]     out_row_position,
  output logic [csf_pkg::TAG_W-1:0]     out_file_tag,
  output logic                          out_batch_end,
  // configuration
  input  logic                          cfg_we,
  input  logic [csf_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [csf_pkg::CFG_W-1:0]     cfg_data
);
  import csf_pkg::*;
  `include "assert_macros.svh"

  localparam int MW     = MODULUS_WIDTH;
  localparam int STEPS  = P_W;
  localparam int USED   = (PRIOR_SLOTS < PRIOR_REGS) ? PRIOR_SLOTS : PRIOR_REGS;
  localparam int MI_W   = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int SLOT_W = $clog2(SLOT_COUNT);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  // ---------------------------------------------------------------- config
  logic [SLOT_COUNT-1:0][MW-1:0] mod_r;
  logic                          triage_r;
  logic [31:0]                   cfg_ext;
  logic                          cfg_mod_wr;

  assign cfg_ext    = {{(32-CFG_W){1'b0}}, cfg_data};
  assign cfg_mod_wr = cfg_we && (cfg_index < CIDX_W'(SLOT_COUNT));

  // new modulus resets to 3, priors to 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r    <= (SLOT_COUNT*MW)'(3);
      triage_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_mod_wr) begin
        mod_r[cfg_index[SLOT_W-1:0]] <= cfg_ext[MW-1:0];
      end else if (cfg_index == REG_TRIAGE) begin
        triage_r <= cfg_data[0];
      end
    end
  end

  // ------------------------------------------------- residue table rebuild
  seq_state_t                 seq_r, seq_nxt;
  logic [SLOT_COUNT-1:0]      dirty_r, dirty_nxt;
  logic [SLOT_W-1:0]          slot_r, slot_nxt, pick;
  logic [MI_W-1:0]            midx_r, midx_nxt;
  logic [MW-1:0]              cur_r, cur_nxt, step_val;
  logic [MW:0]                dbl;
  logic                       seq_done, seq_restart, busy;
  logic [MW-1:0]              res_r [SLOT_COUNT][MAX_POSITIONS];

  assign busy        = (dirty_r != '0);
  assign seq_done    = (midx_r == MI_W'(MAX_POSITIONS - 1));
  assign seq_restart = cfg_mod_wr && (cfg_index[SLOT_W-1:0] == slot_r);

  // Lowest dirty slot first
  always_comb begin
    pick = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (dirty_r[i]) pick = SLOT_W'(i);
    end
  end

  // Next power residue: doubling and one conditional subtract
  always_comb begin
    dbl      = {cur_r, 1'b0};
    step_val = dbl[MW-1:0];
    if (dbl >= {1'b0, mod_r[slot_r]}) begin
      step_val = MW'(dbl - {1'b0, mod_r[slot_r]});
    end
  end

  always_comb begin
    seq_nxt   = seq_r;
    slot_nxt  = slot_r;
    midx_nxt  = midx_r;
    cur_nxt   = cur_r;
    dirty_nxt = dirty_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (busy && !cfg_we) begin
          seq_nxt  = SEQ_RUN;
          slot_nxt = pick;
          midx_nxt = '0;
          cur_nxt  = (mod_r[pick] == MW'(1)) ? '0 : MW'(1);
        end
      end
      SEQ_RUN: begin
        if (seq_restart) begin
          seq_nxt = SEQ_IDLE;
        end else begin
          cur_nxt  = step_val;
          midx_nxt = midx_r + MI_W'(1);
          if (seq_done) begin
            seq_nxt = SEQ_IDLE;
            dirty_nxt[slot_r] = 1'b0;
          end
        end
      end
      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
    if (cfg_mod_wr) begin
      dirty_nxt[cfg_index[SLOT_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= SEQ_IDLE;
      dirty_r <= SLOT_COUNT'(1);
      slot_r  <= '0;
      midx_r  <= '0;
    end else begin
      seq_r   <= seq_nxt;
      dirty_r <= dirty_nxt;
      slot_r  <= slot_nxt;
      midx_r  <= midx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (seq_r == SEQ_RUN && !seq_restart) begin
      res_r[slot_r][midx_r] <= step_val;
    end
  end

  // ------------------------------------------------------ bit-step pipeline
  logic       adv;
  logic       out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = busy || !adv;

  stage_ctl_t                      ctl_s [STEPS+1];
  logic [P_W-1:0]                  p_s   [STEPS+1];
  row_tag_t                        tag_s [STEPS+1];
  logic [SLOT_COUNT-1:0][MW-1:0]   rem_s [STEPS+1];

  always_comb begin
    ctl_s[0].valid = in_valid && !busy;
    ctl_s[0].lead  = 1'b0;
    ctl_s[0].msb   = '0;
    ctl_s[0].ones  = '0;
    ctl_s[0].last  = 1'b0;
    p_s[0]         = in_prime_value;
    tag_s[0].row   = in_row_position;
    tag_s[0].file  = in_file_tag;
    tag_s[0].batch_last = in_batch_last;
    rem_s[0]       = '0;
  end

  // Stage k consumes bit P_W-1-k of p, most significant first
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    csf_mod_step #(
      .MODULUS_WIDTH (MW),
      .BIT_POS       (STEPS - 1 - k)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_s[k]),
      .p_i   (p_s[k]),
      .tag_i (tag_s[k]),
      .rem_i (rem_s[k]),
      .mod_i (mod_r),
      .ctl_o (ctl_s[k+1]),
      .p_o   (p_s[k+1]),
      .tag_o (tag_s[k+1]),
      .rem_o (rem_s[k+1])
    );
  end

  // ------------------------------------------------ residue compare stage
  stage_ctl_t                 fin;
  logic [MAX_POSITIONS-1:0]   hit_new, hit_prior;
  logic [RES_W-1:0]           full_c, triv_c;
  logic                       mpos_c;

  assign fin    = ctl_s[STEPS];
  assign mpos_c = fin.lead && (fin.msb != '0);

  always_comb begin
    hit_new   = '0;
    hit_prior = '0;
    for (int j = 0; j < MAX_POSITIONS; j++) begin
      hit_new[j] = (mod_r[0] != '0) && (res_r[0][j] == rem_s[STEPS][0]);
      for (int i = 1; i <= USED; i++) begin
        if (mod_r[i] != '0 && res_r[i][j] == rem_s[STEPS][i]) hit_prior[j] = 1'b1;
      end
    end
  end

  // Positions 1..M and the trivial top position of p = 2^M + 1
  always_comb begin
    for (int j = 0; j < RES_W; j++) begin
      full_c[j] = fin.lead && (LOG_W'(j) < fin.msb);
      triv_c[j] = mpos_c && (fin.ones == 2'd1) && fin.last && (LOG_W'(j + 1) == fin.msb);
    end
  end

  logic                  c_valid_r;
  logic [RES_W-1:0]      c_full_r, c_new_r, c_prior_r;
  logic                  c_mpos_r;
  row_tag_t              c_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_full_r  <= full_c;
      c_new_r   <= (RES_W'(hit_new) & full_c) | triv_c;
      c_prior_r <= RES_W'(hit_prior);
      c_mpos_r  <= mpos_c;
      c_tag_r   <= tag_s[STEPS];
    end
  end

  // ---------------------------------------------------------- output stage
  logic [RES_W-1:0] cov;
  logic             covered_c;
  logic [RES_W-1:0] residual_c;

  always_comb begin
    cov        = (c_new_r | c_prior_r) & c_full_r;
    covered_c  = c_mpos_r && (triage_r || c_new_r != '0) && (cov == c_full_r);
    residual_c = '0;
    if (triage_r && c_mpos_r && !covered_c) begin
      residual_c = c_full_r & ~cov;
    end
  end

  logic             out_covered_r;
  logic [RES_W-1:0] out_residual_r;
  row_tag_t         out_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_covered_r  <= covered_c;
      out_residual_r <= residual_c;
      out_tag_r      <= c_tag_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_covered       = out_covered_r;
  assign out_residual_mask = out_residual_r;
  assign out_row_position  = out_tag_r.row;
  assign out_file_tag      = out_tag_r.file;
  assign out_batch_end     = out_tag_r.batch_last;

  // ------------------------------------------------------------ assertions
  `CSF_ASSERT_IMPL(a_no_accept_in_rebuild, clk, rst_n, in_valid && !in_stall, seq_r == SEQ_IDLE && dirty_r == '0)
  `CSF_ASSERT_IMPL(a_covered_no_residual, clk, rst_n, out_valid && out_covered, out_residual_mask == '0)
  `CSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_tag_r))
  `CSF_ASSERT_NEXT(a_done_clears_dirty, clk, rst_n, seq_r == SEQ_RUN && seq_done && !seq_restart && !cfg_we, seq_r == SEQ_IDLE)

endmodule
